// File: sv/mi4_pkg.sv
package mi4_pkg;

    localparam int ELEM_W = 32;
    localparam int TOL_W  = 16;
    localparam int M2W    = 65;
    localparam int PROD_W = 65;
    localparam int CW     = 97;
    localparam int DW     = 131;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     first_element;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inverse_element;
        logic signed [ELEM_W-1:0] det_value;
        logic                     singular;
        logic                     saturated;
        logic                     last_result;
    } t_out_item;

    typedef struct packed {
        logic       mul_en;
        logic       acc_en;
        logic       to_m2;
        logic       clear;
        logic       negate;
        logic [1:0] chunk;
    } t_mac_ctl;

    typedef struct packed {
        logic              done;
        logic              big;
        logic [ELEM_W-1:0] quo;
    } t_div_res;

    function automatic logic [1:0] f_skip(input logic [1:0] i, input logic [1:0] x);
        f_skip = (i >= x) ? i + 2'd1 : i;
    endfunction

endpackage

// File: sv/mi4_mac.sv
module mi4_mac (
    input  logic                             i_clk,
    input  mi4_pkg::t_mac_ctl                i_ctl,
    input  logic signed [mi4_pkg::ELEM_W-1:0] i_a,
    input  logic signed [mi4_pkg::ELEM_W:0]   i_b,
    output logic signed [mi4_pkg::DW-1:0]     o_sum,
    output logic signed [mi4_pkg::DW-1:0]     o_acc,
    output logic signed [mi4_pkg::M2W-1:0]    o_m2
);
    import mi4_pkg::*;

    logic signed [PROD_W-1:0] w_a_ext;
    logic signed [PROD_W-1:0] w_b_ext;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DW-1:0]     w_ext;
    logic signed [DW-1:0]     w_addend;
    logic signed [DW-1:0]     w_base;
    logic signed [DW-1:0]     r_acc;
    logic signed [M2W-1:0]    r_m2;

    assign w_a_ext = PROD_W'(i_a);
    assign w_b_ext = PROD_W'(i_b);
    assign w_ext   = DW'(r_prod);

    always_comb begin
        unique case (i_ctl.chunk)
            2'd0:    w_addend = w_ext;
            2'd1:    w_addend = w_ext <<< 32;
            2'd2:    w_addend = w_ext <<< 64;
            default: w_addend = w_ext;
        endcase
    end

    always_comb begin
        priority if (i_ctl.clear) begin
            w_base = '0;
        end else if (i_ctl.to_m2) begin
            w_base = DW'(r_m2);
        end else begin
            w_base = r_acc;
        end
    end

    assign o_sum = i_ctl.negate ? w_base - w_addend : w_base + w_addend;
    assign o_acc = r_acc;
    assign o_m2  = r_m2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_a_ext * w_b_ext;
        end
        if (i_ctl.acc_en) begin
            if (i_ctl.to_m2) begin
                r_m2 <= M2W'(o_sum);
            end else begin
                r_acc <= o_sum;
            end
        end
    end

endmodule

// File: sv/mi4_div.sv
module mi4_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [mi4_pkg::CW-1:0] i_cof,
    input  logic [mi4_pkg::DW-1:0]        i_dmag,
    output mi4_pkg::t_div_res             o_res
);
    import mi4_pkg::*;

    localparam int NW   = CW + 2 * FRAC_BITS;
    localparam int HW   = NW - 32;
    localparam int CMPW = (HW > DW) ? HW : DW;

    logic [CW-1:0]     w_mag;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_rem;
    logic [31:0]       r_low;
    logic [31:0]       r_quo;
    logic              r_big;
    logic              r_busy;
    logic              r_pre;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic              w_big;
    logic [DW:0]       w_trial;
    logic              w_fit;

    assign w_mag   = i_cof[CW-1] ? CW'(-i_cof) : CW'(i_cof);
    assign w_big   = CMPW'(r_num[NW-1:32]) >= CMPW'(i_dmag);
    assign w_trial = {r_rem, r_low[31]};
    assign w_fit   = w_trial >= {1'b0, i_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pre  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pre  <= 1'b1;
            end else if (r_busy && r_pre) begin
                r_pre <= 1'b0;
                r_cnt <= '0;
                if (w_big) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NW'(w_mag) << (2 * FRAC_BITS);
        end else if (r_busy && r_pre) begin
            r_big <= w_big;
            r_rem <= DW'(r_num[NW-1:32]);
            r_low <= r_num[31:0];
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? DW'(w_trial - {1'b0, i_dmag}) : DW'(w_trial);
            r_low <= {r_low[30:0], 1'b0};
            r_quo <= {r_quo[30:0], w_fit};
        end
    end

    assign o_res.done = r_done;
    assign o_res.big  = r_big;
    assign o_res.quo  = r_quo;

endmodule

// File: sv/matrix_inverse_4x4_top.sv
// 4x4 matrix inverse by the adjugate, signed fixed point with FRAC_BITS fraction bits.
// Input channel (i_in_valid / o_in_ready): one matrix element per transfer, row-major;
// first_element restarts the load at row 0 column 0. Elements not at index 15 only load.
// The transfer that stores index 15 starts the solve; o_in_ready stays low until the
// sixteenth result has been transferred.
// Output channel (o_out_valid / i_out_ready): sixteen results, row-major, last_result
// on the final one. Each carries the entry, the determinant and the flags.
// The cofactor multiply-accumulate and then the determinant run on the single 32x33
// multiplier; S_ABS and S_FIN normalize the determinant; then each entry passes the
// shared restoring divider and the output register; the divider stops early when the
// quotient overflows 32 bits and is skipped when the matrix is singular.
// A stalled receiver holds the current result; the solve simply pauses.
// Singular matrices give sixteen zero entries with singular set.
// Reset (synchronous, active low) clears the load index, the tolerance and all control
// state; the element store holds no reset value. The user writes the tolerance through
// i_cfg_we / i_cfg_wdata only while the block is idle; the block does not enforce it.
module matrix_inverse_4x4_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mi4_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mi4_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [mi4_pkg::TOL_W-1:0]      i_cfg_wdata
);
    import mi4_pkg::*;

    localparam int DTW = DW - 3 * FRAC_BITS;
    localparam logic [1:0] PH_RD  = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_ACC = 2'd2;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_COF   = 8'b0000_0010,
        S_DET   = 8'b0000_0100,
        S_ABS   = 8'b0000_1000,
        S_FIN   = 8'b0001_0000,
        S_ENTRY = 8'b0010_0000,
        S_DWAIT = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [31:0] value;
        logic        clip;
    } t_sat;

    function automatic t_sat f_sat(input logic [31:0] mag, input logic big, input logic neg);
        t_sat        res;
        logic [31:0] lim;
        lim       = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        res.clip  = big || (mag > lim);
        res.value = res.clip ? lim : (neg ? (~mag + 32'd1) : mag);
        f_sat     = res;
    endfunction

    t_state                r_state, n_state;
    logic [1:0]            r_ph;
    logic [1:0]            r_sub;
    logic [1:0]            r_k;
    logic [3:0]            r_ci;
    logic [3:0]            r_ent;
    logic [3:0]            r_load_cnt;
    logic [TOL_W-1:0]      r_tol;
    logic [ELEM_W-1:0]     r_mem [16];
    logic [ELEM_W-1:0]     r_rd_a;
    logic [ELEM_W-1:0]     r_rd_b;
    logic signed [CW-1:0]  r_cof [16];
    logic                  r_dneg;
    logic [DW-1:0]         r_dmag;
    logic                  r_sing;
    logic                  r_dclip;
    logic [31:0]           r_det_raw;
    logic                  r_eneg;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic [3:0]            w_idx;
    logic [1:0]            w_r, w_c;
    logic [1:0]            w_rr0, w_rr1, w_rr2, w_ca, w_cb;
    logic [3:0]            w_addr_a, w_addr_b;
    logic [3:0]            w_cof_idx;
    logic signed [CW-1:0]  w_cof_rd;
    logic signed [ELEM_W:0] w_b;
    logic                  w_cof_neg;
    t_mac_ctl              w_ctl;
    logic signed [DW-1:0]  w_sum, w_acc;
    logic signed [M2W-1:0] w_m2;
    logic                  w_mac_run;
    logic                  w_cof_last;
    logic                  w_det_last;
    logic [DTW-1:0]        w_dtr;
    t_sat                  w_dsat;
    t_sat                  w_esat;
    logic                  w_div_start;
    t_div_res              w_div;

    assign o_in_ready  = (r_state == S_LOAD);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = r_out_valid && i_out_ready;
    assign w_idx       = i_in_data.first_element ? 4'd0 : r_load_cnt;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_r   = r_ci[3:2];
    assign w_c   = r_ci[1:0];
    assign w_rr0 = f_skip(2'd0, w_r);
    assign w_rr1 = f_skip(2'd1, w_r);
    assign w_rr2 = f_skip(2'd2, w_r);
    assign w_ca  = f_skip((r_k == 2'd0) ? 2'd1 : 2'd0, w_c);
    assign w_cb  = f_skip((r_k == 2'd2) ? 2'd1 : 2'd2, w_c);

    always_comb begin
        if (r_state == S_DET) begin
            w_addr_a = {2'b00, w_c};
            w_addr_b = {2'b00, w_c};
        end else begin
            unique case (r_sub)
                2'd0: begin
                    w_addr_a = {w_rr1, w_ca};
                    w_addr_b = {w_rr2, w_cb};
                end
                2'd1: begin
                    w_addr_a = {w_rr1, w_cb};
                    w_addr_b = {w_rr2, w_ca};
                end
                default: begin
                    w_addr_a = {w_rr0, f_skip(r_k, w_c)};
                    w_addr_b = {w_rr0, f_skip(r_k, w_c)};
                end
            endcase
        end
    end

    assign w_cof_idx = (r_state == S_DET) ? {2'b00, w_c} : {r_ent[1:0], r_ent[3:2]};
    assign w_cof_rd  = r_cof[w_cof_idx];

    always_comb begin
        if (r_state == S_DET) begin
            unique case (r_k)
                2'd0:    w_b = {1'b0, w_cof_rd[31:0]};
                2'd1:    w_b = {1'b0, w_cof_rd[63:32]};
                default: w_b = w_cof_rd[96:64];
            endcase
        end else begin
            unique case (r_sub)
                2'd0, 2'd1: w_b = (ELEM_W + 1)'(signed'(r_rd_b));
                2'd2:       w_b = {1'b0, w_m2[31:0]};
                default:    w_b = w_m2[64:32];
            endcase
        end
    end

    assign w_mac_run = (r_state == S_COF) || (r_state == S_DET);
    assign w_cof_neg = (r_k == 2'd1) ^ w_r[0] ^ w_c[0];

    always_comb begin
        w_ctl.mul_en = w_mac_run && (r_ph == PH_MUL);
        w_ctl.acc_en = w_mac_run && (r_ph == PH_ACC);
        if (r_state == S_DET) begin
            w_ctl.to_m2  = 1'b0;
            w_ctl.clear  = (w_c == 2'd0) && (r_k == 2'd0);
            w_ctl.negate = 1'b0;
            w_ctl.chunk  = r_k;
        end else begin
            w_ctl.to_m2  = (r_sub < 2'd2);
            w_ctl.clear  = (r_sub == 2'd0) || ((r_sub == 2'd2) && (r_k == 2'd0));
            w_ctl.negate = (r_sub == 2'd1) || ((r_sub >= 2'd2) && w_cof_neg);
            w_ctl.chunk  = (r_sub == 2'd3) ? 2'd1 : 2'd0;
        end
    end

    mi4_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (signed'(r_rd_a)),
        .i_b   (w_b),
        .o_sum (w_sum),
        .o_acc (w_acc),
        .o_m2  (w_m2)
    );

    assign w_cof_last = (r_ph == PH_ACC) && (r_sub == 2'd3) && (r_k == 2'd2);
    assign w_det_last = (r_ph == PH_ACC) && (r_k == 2'd2) && (w_c == 2'd3);

    assign w_dtr  = DTW'(r_dmag >> (3 * FRAC_BITS));
    assign w_dsat = f_sat(w_dtr[31:0], |w_dtr[DTW-1:32], r_dneg);
    assign w_esat = f_sat(w_div.quo, w_div.big, r_eneg);

    assign w_div_start = (r_state == S_ENTRY) && !r_sing;

    mi4_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_cof   (w_cof_rd),
        .i_dmag  (r_dmag),
        .o_res   (w_div)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (w_in_xfer && (w_idx == 4'd15)) n_state = S_COF;
            S_COF:   if (w_cof_last && (r_ci == 4'd15)) n_state = S_DET;
            S_DET:   if (w_det_last) n_state = S_ABS;
            S_ABS:   n_state = S_FIN;
            S_FIN:   n_state = S_ENTRY;
            S_ENTRY: n_state = r_sing ? S_OUT : S_DWAIT;
            S_DWAIT: if (w_div.done) n_state = S_OUT;
            S_OUT:   if (w_out_xfer) n_state = (r_ent == 4'd15) ? S_LOAD : S_ENTRY;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ph        <= PH_RD;
            r_sub       <= '0;
            r_k         <= '0;
            r_ci        <= '0;
            r_ent       <= '0;
            r_load_cnt  <= '0;
            r_tol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (w_in_xfer) begin
                r_load_cnt <= w_idx + 4'd1;
            end
            if (w_mac_run) begin
                unique case (r_ph)
                    PH_RD:   r_ph <= PH_MUL;
                    PH_MUL:  r_ph <= PH_ACC;
                    default: r_ph <= PH_RD;
                endcase
            end
            if ((r_state == S_COF) && (r_ph == PH_ACC)) begin
                r_sub <= r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_ci <= r_ci + 4'd1;
                    end
                end
            end
            if ((r_state == S_DET) && (r_ph == PH_ACC)) begin
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_ci <= (w_c == 2'd3) ? 4'd0 : r_ci + 4'd1;
                end
            end
            if (((r_state == S_ENTRY) && r_sing) || ((r_state == S_DWAIT) && w_div.done)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
                r_ent       <= r_ent + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mem[w_idx] <= i_in_data.element;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_COF) && w_cof_last) begin
            r_cof[r_ci] <= CW'(w_sum);
        end
        if (r_state == S_ABS) begin
            r_dneg <= w_acc[DW-1];
            r_dmag <= w_acc[DW-1] ? DW'(-w_acc) : DW'(w_acc);
        end
        if (r_state == S_FIN) begin
            r_sing    <= (w_dtr[DTW-1:TOL_W] == '0) && (w_dtr[TOL_W-1:0] <= r_tol);
            r_dclip   <= w_dsat.clip;
            r_det_raw <= w_dsat.value;
        end
        if (r_state == S_ENTRY) begin
            r_eneg <= w_cof_rd[CW-1] ^ r_dneg;
            if (r_sing) begin
                r_out.inverse_element <= '0;
                r_out.det_value       <= r_det_raw;
                r_out.singular        <= 1'b1;
                r_out.saturated       <= r_dclip;
                r_out.last_result     <= (r_ent == 4'd15);
            end
        end
        if ((r_state == S_DWAIT) && w_div.done) begin
            r_out.inverse_element <= w_esat.value;
            r_out.det_value       <= r_det_raw;
            r_out.singular        <= 1'b0;
            r_out.saturated       <= r_dclip | w_esat.clip;
            r_out.last_result     <= (r_ent == 4'd15);
        end
    end

`ifndef SYNTH
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.singular) |-> (o_out_data.inverse_element == '0))
        else $error("singular result carries a nonzero entry");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out_data.last_result) |=> o_in_ready)
        else $error("block not ready after the last transfer");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DWAIT))
        else $error("divider finished outside the wait state");
`endif

endmodule

// File: tb/tb_matrix_inverse_4x4_top.sv
`timescale 1ns / 100ps

module tb_matrix_inverse_4x4_top;
    import mi4_pkg::*;

    localparam int FRAC      = 16;
    localparam int CYC_LIMIT = 400000;
    localparam int LONG_HOLD = 3000;

    typedef enum int {
        MX_FULL, MX_SMALL, MX_DIAG, MX_DUP_ROW, MX_EXTREME, MX_TINY, MX_KINDS
    } t_mx_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [TOL_W-1:0]     i_cfg_wdata = '0;

    matrix_inverse_4x4_top #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 i_clk = ~i_clk;

    t_in_item   element_q[$];
    t_out_item  inverse_q[$];
    logic [31:0] elem_store[16];
    logic [3:0]  load_idx = '0;
    logic [15:0] tol_shadow = '0;
    int          snd_idle = 0, rcv_idle = 0;
    int          n_errors = 0, n_elements = 0, n_results = 0, n_singular = 0, n_sat = 0;
    int          cycles = 0;
    bit          hold_arm = 0, hold_used = 0;
    int          hold_cnt = 0;

    function automatic logic signed [191:0] elem_at(int r, int c);
        logic signed [31:0] v;
        v = elem_store[r*4 + c];
        return v;
    endfunction

    function automatic logic signed [191:0] cofactor_of(int row, int col);
        int rr[3], cc[3], n, ca, cb;
        int pa[3], pb[3];
        logic signed [191:0] acc, m2, t;
        pa = '{1, 0, 0};
        pb = '{2, 2, 1};
        acc = '0;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != row) begin rr[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != col) begin cc[n] = i; n++; end
        for (int k = 0; k < 3; k++) begin
            ca = cc[pa[k]];
            cb = cc[pb[k]];
            m2 = elem_at(rr[1], ca) * elem_at(rr[2], cb) - elem_at(rr[1], cb) * elem_at(rr[2], ca);
            t = elem_at(rr[0], cc[k]) * m2;
            acc = (k == 1) ? acc - t : acc + t;
        end
        return ((row + col) % 2 == 1) ? -acc : acc;
    endfunction

    // {clipped, value}
    function automatic logic [32:0] clip32(logic [191:0] mag, bit neg);
        logic [191:0] lim;
        lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        if (mag > lim) return {1'b1, lim[31:0]};
        return {1'b0, neg ? 32'(-mag[31:0]) : mag[31:0]};
    endfunction

    task automatic solve_inverse();
        logic signed [191:0] cof[4][4];
        logic signed [191:0] det, cv;
        logic [191:0] dmag, dtr, num;
        logic [32:0] ds, es;
        bit dneg, sing;
        t_out_item r;
        det = '0;
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++) cof[a][b] = cofactor_of(a, b);
        for (int c = 0; c < 4; c++) det = det + elem_at(0, c) * cof[0][c];
        dneg = det[191];
        dmag = dneg ? -det : det;
        dtr = dmag >> (3*FRAC);
        sing = (dtr <= {176'd0, tol_shadow});
        ds = clip32(dtr, dneg);
        for (int k = 0; k < 16; k++) begin
            r = '0;
            r.det_value = ds[31:0];
            r.singular = sing;
            r.saturated = ds[32];
            r.last_result = (k == 15);
            if (!sing) begin
                cv = cof[k % 4][k / 4];
                num = (cv[191] ? -cv : cv) << (2*FRAC);
                es = clip32(num / dmag, cv[191] != dneg);
                r.inverse_element = es[31:0];
                r.saturated = ds[32] | es[32];
            end
            inverse_q.push_back(r);
        end
    endtask

    task automatic load_element(t_in_item it);
        logic [3:0] idx;
        idx = it.first_element ? 4'd0 : load_idx;
        elem_store[idx] = it.element;
        load_idx = idx + 4'd1;
        if (idx == 4'd15) solve_inverse();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                load_element(i_in_data);
                n_elements++;
            end
            if (element_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                i_in_valid <= 1'b1;
                i_in_data <= element_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (inverse_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_errors++;
                end else begin
                    e = inverse_q.pop_front();
                    n_results++;
                    if (e.singular) n_singular++;
                    if (e.saturated) n_sat++;
                    if (o_out_data.inverse_element !== e.inverse_element) begin
                        $error("inverse_element exp %h got %h", e.inverse_element,
                               o_out_data.inverse_element);
                        n_errors++;
                    end
                    if (o_out_data.det_value !== e.det_value) begin
                        $error("det_value exp %h got %h", e.det_value, o_out_data.det_value);
                        n_errors++;
                    end
                    if (o_out_data.singular !== e.singular) begin
                        $error("singular exp %b got %b", e.singular, o_out_data.singular);
                        n_errors++;
                    end
                    if (o_out_data.saturated !== e.saturated) begin
                        $error("saturated exp %b got %b", e.saturated, o_out_data.saturated);
                        n_errors++;
                    end
                    if (o_out_data.last_result !== e.last_result) begin
                        $error("last_result exp %b got %b", e.last_result,
                               o_out_data.last_result);
                        n_errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else if (hold_arm && !hold_used && o_out_valid) begin
                hold_used <= 1'b1;
                hold_cnt <= LONG_HOLD;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value(t_mx_kind kind, int r, int c);
        logic [31:0] ext[5];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
        case (kind)
            MX_FULL:    return $urandom;
            MX_SMALL:   return 32'($signed($urandom_range(524288)) - 262144);
            MX_DIAG:    return (r == c) ? 32'($urandom_range(300000, 40000))
                                        : 32'($signed($urandom_range(20000)) - 10000);
            MX_EXTREME: return ext[$urandom_range(4)];
            MX_TINY:    return 32'($signed($urandom_range(600)) - 300);
            default:    return $urandom;
        endcase
    endfunction

    task automatic queue_matrix(t_mx_kind kind);
        t_in_item it;
        logic [31:0] row0[4];
        for (int i = 0; i < 16; i++) begin
            it.first_element = (i == 0);
            if (kind == MX_DUP_ROW && i >= 12) it.element = row0[i-12];
            else it.element = pick_value(kind == MX_DUP_ROW ? MX_SMALL : kind, i / 4, i % 4);
            if (i < 4) row0[i] = it.element;
            element_q.push_back(it);
        end
    endtask

    task automatic queue_noise();
        t_in_item it;
        int n;
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) begin
            it.element = $urandom;
            it.first_element = 1'($urandom_range(1));
            element_q.push_back(it);
        end
    endtask

    task automatic write_tolerance(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        tol_shadow = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (element_q.size() > 0 || i_in_valid || inverse_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_phase(int sidle, int ridle, logic [15:0] tol, int n_mx);
        write_tolerance(tol);
        snd_idle = sidle;
        rcv_idle = ridle;
        for (int m = 0; m < n_mx; m++) begin
            if ($urandom_range(3) == 0) queue_noise();
            queue_matrix(t_mx_kind'($urandom_range(MX_KINDS - 1)));
        end
        drain();
    endtask

    initial begin
        t_in_item it;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray elements, identity, then a tiny diagonal under the widest tolerance
        write_tolerance(16'h0000);
        it.element = 32'h7FFF_FFFF; it.first_element = 1'b0; element_q.push_back(it);
        it.element = 32'h8000_0000; it.first_element = 1'b1; element_q.push_back(it);
        for (int i = 0; i < 16; i++) begin
            it.first_element = (i == 0);
            it.element = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
            element_q.push_back(it);
        end
        drain();
        write_tolerance(16'hFFFF);
        for (int i = 0; i < 16; i++) begin
            it.first_element = (i == 0);
            it.element = (i % 5 == 0) ? 32'h0000_0001 : 32'h0;
            element_q.push_back(it);
        end
        drain();

        hold_arm = 1;
        random_phase(34, 64, 16'h0000, 6);
        random_phase(34, 64, 16'($urandom), 2);
        random_phase(64, 34, 16'hFFFF, 4);
        random_phase(64, 34, 16'h0001, 3);
        random_phase(0, 0, 16'($urandom), 4);

        $display("covered %0d element transfers, %0d result transfers", n_elements, n_results);
        $display("singular results %0d, saturated results %0d", n_singular, n_sat);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
